FILE: rtl/core/b64e_pkg.sv
// Shared types, constants and the alphabet function of the Base64 stream encoder.
package b64e_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0] PAD_CHAR = 7'd61;

  typedef enum logic [1:0] {
    PH0 = 2'd0,
    PH1 = 2'd1,
    PH2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [3:0][6:0] sym;
    logic [1:0]      last_idx;
    logic            fin;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_head_t;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'(v) + 7'd65;
    end else if (v < 6'd52) begin
      r = 7'(v) + 7'd71;
    end else if (v < 6'd62) begin
      r = 7'(v) - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'd43;
    end else begin
      r = 7'd47;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/b64e_front.sv
// Front end: accepts bytes, tracks group position and builds symbol entries.
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_fin,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output b64e_pkg::entry_t push_entry
);
  import b64e_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry = '0;
    push_entry.fin = in_fin;
    unique case (phase_r)
      PH1: begin
        push_entry.sym[0] = enc6({carry_r[1:0], in_byte[7:4]});
        push_entry.sym[1] = enc6({in_byte[3:0], 2'b00});
        push_entry.sym[2] = PAD_CHAR;
        push_entry.last_idx = in_fin ? 2'd2 : 2'd0;
        phase_nxt = PH2;
        carry_nxt = in_byte[3:0];
      end
      PH2: begin
        push_entry.sym[0] = enc6({carry_r, in_byte[7:6]});
        push_entry.sym[1] = enc6(in_byte[5:0]);
        push_entry.last_idx = 2'd1;
        phase_nxt = PH0;
        carry_nxt = 4'd0;
      end
      default: begin
        push_entry.sym[0] = enc6(in_byte[7:2]);
        push_entry.sym[1] = enc6({in_byte[1:0], 4'b0000});
        push_entry.sym[2] = PAD_CHAR;
        push_entry.sym[3] = PAD_CHAR;
        push_entry.last_idx = in_fin ? 2'd3 : 2'd0;
        phase_nxt = PH1;
        carry_nxt = {2'b00, in_byte[1:0]};
      end
    endcase
    if (in_fin) begin
      phase_nxt = PH0;
      carry_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

FILE: rtl/core/b64e_queue.sv
// Short queue of symbol entries between front end and back end.
module b64e_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output b64e_pkg::q_head_t q_head
);
  import b64e_pkg::*;

  entry_t           slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;

  assign full          = (count_r == (QAW+1)'(QDEPTH));
  assign q_head.valid  = (count_r != '0);
  assign q_head.head   = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/b64e_back.sv
// Back end: steps through each entry and drives one symbol per output transfer.
module b64e_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64e_pkg::q_head_t q_head,
  input  logic              out_ready,
  output logic              pop,
  output logic              out_valid,
  output logic [6:0]        out_sym,
  output logic              out_last
);
  import b64e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] sym_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign load   = q_head.valid && (!valid_r || out_ready);
  assign at_end = (idx_r == q_head.head.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_r  <= q_head.head.sym[idx_r];
      last_r <= at_end && q_head.head.fin;
    end
  end

  assign out_valid = valid_r;
  assign out_sym   = sym_r;
  assign out_last  = last_r;

endmodule

FILE: rtl/core/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, entry queue and back end.
//
//   channel | direction | tdata                  | tlast
//   in_     | slave     | [7:0] data_byte        | final_byte
//   out_    | master     | [6:0] symbol, [7] zero | last_symbol
//
// Input takes one byte per cycle while the queue has room; each byte yields
// one to four symbols. Output moves one symbol per cycle from its register
// while out_tready is high, which bounds sustained input. A byte reaches the
// output through a queue slot and then the output register.
// Reset clears group position, queue pointers and output valid.
// Either side may stall; the queue absorbs up to four pending bytes.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] symbol, [7] zero
  output logic       out_tlast
);
  import b64e_pkg::*;

  logic      push;
  logic      pop;
  logic      q_full;
  entry_t    push_entry;
  q_head_t   q_head;
  logic [6:0] sym;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_fin     (in_tlast),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_head     (q_head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .out_ready (out_tready),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_sym   (sym),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, sym};

endmodule

FILE: test/base64_stream_encoder_tb.sv
// Testbench for the Base64 stream encoder: random and directed byte messages checked per symbol.
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
  import b64e_pkg::*;

  localparam int DIR_N      = 18;
  localparam int RAND_ITEMS = 300;
  localparam int CYCLE_CAP  = 200000;

  class symbol_scoreboard;
    phase_t     phase;
    logic [3:0] carry;
    logic [7:0] want_q[$];
    int         errors;
    string      alphabet;

    function new();
      phase    = PH0;
      carry    = '0;
      errors   = 0;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function logic [6:0] char_of(logic [5:0] v);
      return 7'(alphabet.getc(int'(v)));
    endfunction

    function void push_sym(logic [6:0] s, logic l);
      want_q.push_back({l, s});
    endfunction

    function void note_byte(logic [7:0] d, logic fin);
      case (phase)
        PH1: begin
          push_sym(char_of({carry[1:0], d[7:4]}), 1'b0);
          if (fin) begin
            push_sym(char_of({d[3:0], 2'b00}), 1'b0);
            push_sym(PAD_CHAR, 1'b1);
          end
          phase = PH2;
          carry = d[3:0];
        end
        PH2: begin
          push_sym(char_of({carry, d[7:6]}), 1'b0);
          push_sym(char_of(d[5:0]), fin);
          phase = PH0;
          carry = '0;
        end
        default: begin
          push_sym(char_of(d[7:2]), 1'b0);
          if (fin) begin
            push_sym(char_of({d[1:0], 4'b0000}), 1'b0);
            push_sym(PAD_CHAR, 1'b0);
            push_sym(PAD_CHAR, 1'b1);
          end
          phase = PH1;
          carry = {2'b00, d[1:0]};
        end
      endcase
      if (fin) begin
        phase = PH0;
        carry = '0;
      end
    endfunction

    task report(string what);
      if (errors < 50) begin
        $display("mismatch: %s", what);
      end
      errors++;
    endtask

    task check_symbol(logic [7:0] tdata, logic tlast);
      logic [7:0] want;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected symbol tdata=0x%02h tlast=%b", tdata, tlast));
        return;
      end
      want = want_q.pop_front();
      if (tdata[6:0] !== want[6:0]) begin
        report($sformatf("symbol 0x%02h, want 0x%02h", tdata[6:0], want[6:0]));
      end
      if (tlast !== want[7]) begin
        report($sformatf("last_symbol %b, want %b on 0x%02h", tlast, want[7], want[6:0]));
      end
      if (tdata[7] !== 1'b0) begin
        report("tdata pad bit set");
      end
    endtask

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  symbol_scoreboard sb = new();

  logic       idle_on = 1'b1;
  int         sent = 0;
  int         stall_left = 0;
  int         cycles = 0;

  logic [7:0] dir_bytes [DIR_N] = '{8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00,
                                    8'haa, 8'h55, 8'h0f, 8'hff, 8'hff, 8'hff, 8'hf0,
                                    8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
  logic       dir_fin   [DIR_N] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                    1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  base64_stream_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [6:0] symbol, [7] zero
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("base64_stream_encoder_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_symbol(out_tdata, out_tlast);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(d, fin);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int msg_len;
    bit drained;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      idle_gap();
      send_byte(dir_bytes[i], dir_fin[i]);
    end

    while (sent < DIR_N + RAND_ITEMS) begin
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int k = 0; k < msg_len; k++) begin
        if (sent > DIR_N + RAND_ITEMS - 60) begin
          idle_on = 1'b0;
        end
        idle_gap();
        send_byte(8'($urandom), k == msg_len - 1);
      end
      if (!drained && sent > 150) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        drained = 1'b1;
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("base64_stream_encoder_tb: clean");
    end else begin
      $display("base64_stream_encoder_tb: errors");
    end
    $finish;
  end

endmodule
